// ----- rtl/mhu_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and the CORDIC angle table for the magnetometer heading unit.
// No dependencies; every other file in rtl/ refers to this package by scoped names.

package mhu_pkg;

   localparam int ANGLE_FRAC_BITS = 6;
   localparam int HEADING_BITS    = 9 + ANGLE_FRAC_BITS;
   localparam int FULL_TURN       = 360 << ANGLE_FRAC_BITS;
   localparam int CORDIC_STEPS    = 60;
   localparam int STEP_BITS       = $clog2(CORDIC_STEPS);
   localparam int TURN_BITS       = 62;
   localparam int DATA_BITS       = 64;
   localparam int NORM_TOP        = 58;
   localparam int HALF_SPLIT      = 31;
   localparam int PROD_BITS       = HALF_SPLIT + HEADING_BITS;

   localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

   // sideband that rides along the pipeline next to the CORDIC vector
   typedef struct packed {
      logic               valid;
      logic               zero;
      logic signed [15:0] x_value;
      logic signed [15:0] y_value;
      logic signed [15:0] z_value;
   } side_type;

   typedef struct packed {
      side_type                        side;
      logic signed [DATA_BITS-1:0]     x;
      logic signed [DATA_BITS-1:0]     y;
      logic        [TURN_BITS-1:0]     z;
   } cordic_type;

   // shift-subtract long division, used only while building the angle table
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      int          b;
      rem = '0;
      quo = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         quo = {quo[62:0], 1'b0};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[0] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(1/n), 60 fraction bits, Gregory series
   function automatic logic [63:0] atan_inv_q60(input logic [63:0] n);
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] d;
      logic        sub;
      term = udiv64(ONE_Q60, n);
      sum  = term;
      d    = 64'd1;
      sub  = 1'b1;
      while (term != 64'd0) begin
         term = udiv64(term, n * n);
         d    = d + 64'd2;
         if (sub) begin
            sum = sum - udiv64(term, d);
         end else begin
            sum = sum + udiv64(term, d);
         end
         sub = !sub;
      end
      return sum;
   endfunction

   // atan(2^-i), 60 fraction bits, i >= 1
   function automatic logic [63:0] atan_pow2_q60(input logic [63:0] i);
      logic [63:0] sum;
      logic [63:0] d;
      logic [63:0] sh;
      logic [63:0] t;
      logic        sub;
      sum = '0;
      d   = 64'd1;
      sh  = i;
      sub = 1'b0;
      while (sh < 64'd61) begin
         t = udiv64(ONE_Q60 >> sh, d);
         if (sub) begin
            sum = sum - t;
         end else begin
            sum = sum + t;
         end
         sub = !sub;
         d   = d + 64'd2;
         sh  = sh + 64'd2 * i;
      end
      return sum;
   endfunction

   // table entry for one step: atan(2^-i) in turns, 62 fraction bits, cut toward zero
   function automatic logic [TURN_BITS-1:0] turn_entry(input int i);
      logic [63:0] pi_q60;
      logic [63:0] r;
      logic [63:0] q;
      int          k;
      if (i == 0) begin
         return TURN_BITS'(64'd1 << 59);
      end
      pi_q60 = 64'd16 * atan_inv_q60(64'd5) - 64'd4 * atan_inv_q60(64'd239);
      r      = atan_pow2_q60(64'(i));
      q      = '0;
      for (k = 0; k < 61; k++) begin
         r = r << 1;
         q = q << 1;
         if (r >= pi_q60) begin
            r    = r - pi_q60;
            q[0] = 1'b1;
         end
      end
      return q[TURN_BITS-1:0];
   endfunction

endpackage

// ----- rtl/mhu_prep.sv -----
`timescale 1ns / 1ps
// Front end: assemble the axis words, fold into the right half plane, normalize.
// Depends on mhu_pkg (side_type, cordic_type, widths).

module mhu_prep (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [7:0]           x_low_byte,
   input  logic [7:0]           x_high_byte,
   input  logic [7:0]           y_low_byte,
   input  logic [7:0]           y_high_byte,
   input  logic [7:0]           z_low_byte,
   input  logic [7:0]           z_high_byte,
   output mhu_pkg::cordic_type  vec_out
);

   // stage one: fold
   mhu_pkg::side_type  side1_in, side1_ff;
   logic signed [16:0] px1_in, px1_ff;
   logic signed [16:0] py1_in, py1_ff;
   logic [16:0]        mag1_in, mag1_ff;
   logic               half1_in, half1_ff;

   logic signed [15:0] xs, ys;
   logic signed [16:0] px0, py0, ap;

   always_comb begin
      xs  = $signed({x_high_byte, x_low_byte});
      ys  = $signed({y_high_byte, y_low_byte});
      px0 = 17'(ys);
      py0 = 17'(xs);
      half1_in = ys[15];
      px1_in   = half1_in ? -px0 : px0;
      py1_in   = half1_in ? -py0 : py0;
      ap       = py1_in[16] ? -py1_in : py1_in;
      mag1_in  = (px1_in > ap) ? px1_in : ap;
      side1_in.valid   = in_valid;
      side1_in.zero    = (xs == 16'sd0) && (ys == 16'sd0);
      side1_in.x_value = xs;
      side1_in.y_value = ys;
      side1_in.z_value = $signed({z_high_byte, z_low_byte});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff.valid <= 1'b0;
      end else begin
         side1_ff.valid <= side1_in.valid;
      end
      side1_ff.zero    <= side1_in.zero;
      side1_ff.x_value <= side1_in.x_value;
      side1_ff.y_value <= side1_in.y_value;
      side1_ff.z_value <= side1_in.z_value;
      px1_ff           <= px1_in;
      py1_ff           <= py1_in;
      mag1_ff          <= mag1_in;
      half1_ff         <= half1_in;
   end

   // stage two: find the leading one and shift it up to bit 58
   mhu_pkg::cordic_type vec2_in, vec2_ff;
   logic [4:0]          lead;
   logic [5:0]          shamt;
   logic [63:0]         pxe, pye;

   always_comb begin
      lead = '0;
      for (int b = 0; b < 17; b++) begin
         if (mag1_ff[b]) begin
            lead = 5'(b);
         end
      end
      shamt = 6'(mhu_pkg::NORM_TOP) - 6'(lead);
      pxe   = {{47{px1_ff[16]}}, px1_ff};
      pye   = {{47{py1_ff[16]}}, py1_ff};
      vec2_in.side = side1_ff;
      vec2_in.x    = $signed(pxe << shamt);
      vec2_in.y    = $signed(pye << shamt);
      vec2_in.z    = half1_ff ? (mhu_pkg::TURN_BITS'(1) << (mhu_pkg::TURN_BITS - 1))
                              : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec2_ff.side.valid <= 1'b0;
      end else begin
         vec2_ff.side.valid <= vec2_in.side.valid;
      end
      vec2_ff.side.zero    <= vec2_in.side.zero;
      vec2_ff.side.x_value <= vec2_in.side.x_value;
      vec2_ff.side.y_value <= vec2_in.side.y_value;
      vec2_ff.side.z_value <= vec2_in.side.z_value;
      vec2_ff.x            <= vec2_in.x;
      vec2_ff.y            <= vec2_in.y;
      vec2_ff.z            <= vec2_in.z;
   end

   assign vec_out = vec2_ff;

endmodule

// ----- rtl/mhu_cordic_cell.sv -----
`timescale 1ns / 1ps
// One CORDIC vectoring step: conditional rotate by atan(2^-step), accumulate angle.
// Depends on mhu_pkg (cordic_type, widths).

module mhu_cordic_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [mhu_pkg::STEP_BITS-1:0]     step,
   input  logic [mhu_pkg::TURN_BITS-1:0]     angle,
   input  mhu_pkg::cordic_type               vec_in,
   output mhu_pkg::cordic_type               vec_out
);

   mhu_pkg::cordic_type             vec_in_next;
   mhu_pkg::cordic_type             vec_ff;
   logic signed [mhu_pkg::DATA_BITS-1:0] dx, dy;

   always_comb begin
      dx = vec_in.y >>> step;
      dy = vec_in.x >>> step;
      vec_in_next.side = vec_in.side;
      if (vec_in.y[mhu_pkg::DATA_BITS-1]) begin
         vec_in_next.x = vec_in.x - dx;
         vec_in_next.y = vec_in.y + dy;
         vec_in_next.z = vec_in.z - angle;
      end else begin
         vec_in_next.x = vec_in.x + dx;
         vec_in_next.y = vec_in.y - dy;
         vec_in_next.z = vec_in.z + angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff.side.valid <= 1'b0;
      end else begin
         vec_ff.side.valid <= vec_in_next.side.valid;
      end
      vec_ff.side.zero    <= vec_in_next.side.zero;
      vec_ff.side.x_value <= vec_in_next.side.x_value;
      vec_ff.side.y_value <= vec_in_next.side.y_value;
      vec_ff.side.z_value <= vec_in_next.side.z_value;
      vec_ff.x            <= vec_in_next.x;
      vec_ff.y            <= vec_in_next.y;
      vec_ff.z            <= vec_in_next.z;
   end

   assign vec_out = vec_ff;

endmodule

// ----- rtl/mhu_scale.sv -----
`timescale 1ns / 1ps
// Back end: scale the angle in turns to 1/64 degree units, round, wrap a full turn to 0; a zero vector gives 0.
// Depends on mhu_pkg (cordic_type, side_type, widths).

module mhu_scale (
   input  logic                                clock,
   input  logic                                reset,
   input  mhu_pkg::cordic_type                 vec_in,
   output mhu_pkg::side_type                   side_out,
   output logic [mhu_pkg::HEADING_BITS-1:0]    heading
);

   localparam logic [mhu_pkg::HEADING_BITS-1:0] FULL =
      mhu_pkg::HEADING_BITS'(mhu_pkg::FULL_TURN);

   // stage one: two narrow partial products
   mhu_pkg::side_type              side_a_ff;
   logic [mhu_pkg::PROD_BITS-1:0]  phi_ff, plo_ff;
   logic [mhu_pkg::PROD_BITS-1:0]  phi_in, plo_in;

   always_comb begin
      phi_in = mhu_pkg::PROD_BITS'(vec_in.z[mhu_pkg::TURN_BITS-1:mhu_pkg::HALF_SPLIT])
               * mhu_pkg::PROD_BITS'(FULL);
      plo_in = mhu_pkg::PROD_BITS'(vec_in.z[mhu_pkg::HALF_SPLIT-1:0])
               * mhu_pkg::PROD_BITS'(FULL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_a_ff.valid <= 1'b0;
      end else begin
         side_a_ff.valid <= vec_in.side.valid;
      end
      side_a_ff.zero    <= vec_in.side.zero;
      side_a_ff.x_value <= vec_in.side.x_value;
      side_a_ff.y_value <= vec_in.side.y_value;
      side_a_ff.z_value <= vec_in.side.z_value;
      phi_ff            <= phi_in;
      plo_ff            <= plo_in;
   end

   // stage two: combine, add half an LSB, wrap
   mhu_pkg::side_type                 side_b_ff;
   logic [mhu_pkg::HEADING_BITS-1:0]  heading_ff, heading_in;
   logic [mhu_pkg::PROD_BITS:0]       total;
   logic [mhu_pkg::PROD_BITS-mhu_pkg::HALF_SPLIT:0] rounded;

   always_comb begin
      total   = {1'b0, phi_ff}
              + (mhu_pkg::PROD_BITS+1)'(plo_ff >> mhu_pkg::HALF_SPLIT)
              + ((mhu_pkg::PROD_BITS+1)'(1) << (mhu_pkg::HALF_SPLIT - 1));
      rounded = total[mhu_pkg::PROD_BITS:mhu_pkg::HALF_SPLIT];
      if (side_a_ff.zero || (rounded >= {1'b0, FULL})) begin
         heading_in = '0;
      end else begin
         heading_in = rounded[mhu_pkg::HEADING_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_b_ff.valid <= 1'b0;
      end else begin
         side_b_ff.valid <= side_a_ff.valid;
      end
      side_b_ff.zero    <= side_a_ff.zero;
      side_b_ff.x_value <= side_a_ff.x_value;
      side_b_ff.y_value <= side_a_ff.y_value;
      side_b_ff.z_value <= side_a_ff.z_value;
      heading_ff        <= heading_in;
   end

   assign side_out = side_b_ff;
   assign heading  = heading_ff;

endmodule

// ----- rtl/magnetometer_heading_unit.sv -----
`timescale 1ns / 1ps
// Magnetometer heading unit: six-byte register burst in, axis words and compass heading out.
// Throughput: one word per clock; busy is always low. Pipeline: 2 fold/normalize stages,
// 60 CORDIC cells and 2 scaling stages lie between the accepting edge and the result strobe.
// Reset (synchronous, active high) clears the valid bits of every stage at once.
// The receiver cannot stall: each result is on rsp_* for exactly one cycle.

module magnetometer_heading_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [7:0]                         req_x_low_byte,
   input  logic [7:0]                         req_x_high_byte,
   input  logic [7:0]                         req_y_low_byte,
   input  logic [7:0]                         req_y_high_byte,
   input  logic [7:0]                         req_z_low_byte,
   input  logic [7:0]                         req_z_high_byte,
   output logic                               rsp_strobe,
   output logic signed [15:0]                 rsp_x_value,
   output logic signed [15:0]                 rsp_y_value,
   output logic signed [15:0]                 rsp_z_value,
   output logic [mhu_pkg::HEADING_BITS-1:0]   rsp_heading_deg64
);

   // every stage advances every cycle, so a new word is taken each clock
   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // chain[0] comes from the front end; chain[i+1] is the output of cell i
   mhu_pkg::cordic_type chain [mhu_pkg::CORDIC_STEPS+1];

   mhu_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .x_low_byte  (req_x_low_byte),
      .x_high_byte (req_x_high_byte),
      .y_low_byte  (req_y_low_byte),
      .y_high_byte (req_y_high_byte),
      .z_low_byte  (req_z_low_byte),
      .z_high_byte (req_z_high_byte),
      .vec_out     (chain[0])
   );

   // row of identical vectoring cells; each one gets its shift and its table angle
   // as constants, worked out at elaboration from the package table
   for (genvar i = 0; i < mhu_pkg::CORDIC_STEPS; i++) begin : g_cell
      localparam logic [mhu_pkg::TURN_BITS-1:0] ANGLE = mhu_pkg::turn_entry(i);

      mhu_cordic_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .step    (mhu_pkg::STEP_BITS'(i)),
         .angle   (ANGLE),
         .vec_in  (chain[i]),
         .vec_out (chain[i+1])
      );
   end

   // scale turns to 1/64 degree and hold the result word for one cycle
   mhu_pkg::side_type side_out;

   mhu_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .vec_in   (chain[mhu_pkg::CORDIC_STEPS]),
      .side_out (side_out),
      .heading  (rsp_heading_deg64)
   );

   assign rsp_strobe  = side_out.valid;
   assign rsp_x_value = side_out.x_value;
   assign rsp_y_value = side_out.y_value;
   assign rsp_z_value = side_out.z_value;

endmodule

// ----- verif/tb_magnetometer_heading_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for magnetometer_heading_unit: directed and random register bursts.
// Depends on rtl/mhu_pkg.sv and rtl/magnetometer_heading_unit.sv; holds its own heading predictor.

module tb_magnetometer_heading_unit;

   localparam int RESET_CYCLES = 8;
   // margin of idle clocks after the results are in, before the final check
   localparam int DRAIN_CYCLES = 80;
   localparam int RANDOM_WORDS = 1630;

   // Predict axis words and heading for each accepted burst, then match
   // results against the oldest prediction in arrival order.
   class heading_scoreboard;
      typedef struct {
         logic signed [15:0]               x_value;
         logic signed [15:0]               y_value;
         logic signed [15:0]               z_value;
         logic [mhu_pkg::HEADING_BITS-1:0] heading;
      } axis_reading_type;

      axis_reading_type expected_q[$];
      bit [63:0]        angle_step[mhu_pkg::CORDIC_STEPS];
      int               mismatches;
      int               checked;

      function new();
         bit [63:0] pi_q60;
         bit [63:0] rem;
         bit [63:0] quo;
         bit [63:0] sum;
         bit [63:0] term;
         bit [63:0] div;
         int        sh;
         bit        neg;
         mismatches = 0;
         checked    = 0;
         pi_q60 = 64'd16 * arctan_recip_q60(64'd5) - 64'd4 * arctan_recip_q60(64'd239);
         angle_step[0] = 64'd1 << 59;
         for (int i = 1; i < mhu_pkg::CORDIC_STEPS; i++) begin
            // atan(2^-i) in radians, 60 fraction bits
            sum = 64'd0;
            div = 64'd1;
            sh  = i;
            neg = 1'b0;
            while (sh < 61) begin
               term = ((64'd1 << 60) >> sh) / div;
               sum  = neg ? sum - term : sum + term;
               neg  = !neg;
               div  = div + 64'd2;
               sh   = sh + 2 * i;
            end
            // convert radians to turns, 62 fraction bits, truncated
            rem = sum;
            quo = 64'd0;
            for (int k = 0; k < 61; k++) begin
               rem = rem << 1;
               quo = quo << 1;
               if (rem >= pi_q60) begin
                  rem    = rem - pi_q60;
                  quo[0] = 1'b1;
               end
            end
            angle_step[i] = quo;
         end
      endfunction

      // atan(1/n) with 60 fraction bits by the Gregory series
      function bit [63:0] arctan_recip_q60(bit [63:0] n);
         bit [63:0] term;
         bit [63:0] sum;
         bit [63:0] div;
         bit        neg;
         term = (64'd1 << 60) / n;
         sum  = term;
         div  = 64'd1;
         neg  = 1'b1;
         while (term != 64'd0) begin
            term = term / (n * n);
            div  = div + 64'd2;
            sum  = neg ? sum - term / div : sum + term / div;
            neg  = !neg;
         end
         return sum;
      endfunction

      function bit [mhu_pkg::HEADING_BITS-1:0] compass_heading(shortint x_axis,
                                                               shortint y_axis);
         longint    vx;
         longint    vy;
         longint    mag;
         longint    dx;
         longint    dy;
         bit [63:0] ang;
         bit [63:0] hi;
         bit [63:0] lo;
         bit [63:0] t;
         bit [63:0] res;
         bit [63:0] full;
         int        sh;
         if (x_axis == 0 && y_axis == 0) begin
            return '0;
         end
         full = 64'(mhu_pkg::FULL_TURN);
         vx  = y_axis;
         vy  = x_axis;
         ang = 64'd0;
         // fold the left half plane over by half a turn
         if (vx < 0) begin
            vx  = -vx;
            vy  = -vy;
            ang = 64'd1 << 61;
         end
         mag = (vy < 0) ? -vy : vy;
         if (vx > mag) begin
            mag = vx;
         end
         sh = 0;
         while ((mag <<< sh) < (64'sd1 <<< 58)) begin
            sh++;
         end
         vx = vx <<< sh;
         vy = vy <<< sh;
         for (int i = 0; i < mhu_pkg::CORDIC_STEPS; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy < 0) begin
               vx  = vx - dx;
               vy  = vy + dy;
               ang = ang - angle_step[i];
            end else begin
               vx  = vx + dx;
               vy  = vy - dy;
               ang = ang + angle_step[i];
            end
         end
         ang = ang & ((64'd1 << 62) - 64'd1);
         // scale turns to 1/64 degree, round half up
         hi  = ang >> 31;
         lo  = ang & ((64'd1 << 31) - 64'd1);
         t   = hi * full + ((lo * full + (64'd1 << 61)) >> 31);
         res = t >> 31;
         if (res >= full) begin
            res = 64'd0;
         end
         return res[mhu_pkg::HEADING_BITS-1:0];
      endfunction

      function void note_reading(bit [7:0] xl, bit [7:0] xh, bit [7:0] yl, bit [7:0] yh,
                                 bit [7:0] zl, bit [7:0] zh);
         axis_reading_type r;
         r.x_value = {xh, xl};
         r.y_value = {yh, yl};
         r.z_value = {zh, zl};
         r.heading = compass_heading(shortint'(r.x_value), shortint'(r.y_value));
         expected_q.push_back(r);
      endfunction

      function void check_result(logic signed [15:0] x_value, logic signed [15:0] y_value,
                                 logic signed [15:0] z_value,
                                 logic [mhu_pkg::HEADING_BITS-1:0] heading);
         axis_reading_type e;
         if (expected_q.size() == 0) begin
            $error("result with no burst outstanding: x=%0d y=%0d z=%0d heading=%0d",
                   x_value, y_value, z_value, heading);
            mismatches++;
            return;
         end
         e = expected_q.pop_front();
         checked++;
         if (x_value !== e.x_value) begin
            $error("x_value: expected %0d, got %0d", e.x_value, x_value);
            mismatches++;
         end
         if (y_value !== e.y_value) begin
            $error("y_value: expected %0d, got %0d", e.y_value, y_value);
            mismatches++;
         end
         if (z_value !== e.z_value) begin
            $error("z_value: expected %0d, got %0d", e.z_value, z_value);
            mismatches++;
         end
         if (heading !== e.heading) begin
            $error("heading_deg64: expected %0d, got %0d (x=%0d y=%0d)",
                   e.heading, heading, e.x_value, e.y_value);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic [7:0]                       req_x_low_byte;
   logic [7:0]                       req_x_high_byte;
   logic [7:0]                       req_y_low_byte;
   logic [7:0]                       req_y_high_byte;
   logic [7:0]                       req_z_low_byte;
   logic [7:0]                       req_z_high_byte;
   logic                             rsp_strobe;
   logic signed [15:0]               rsp_x_value;
   logic signed [15:0]               rsp_y_value;
   logic signed [15:0]               rsp_z_value;
   logic [mhu_pkg::HEADING_BITS-1:0] rsp_heading_deg64;

   heading_scoreboard board = new();

   // words accepted and results seen, bumped at the clock edge by the monitor
   int words_taken  = 0;
   int results_seen = 0;
   int directed_words = 0;
   int drain_pauses = 0;

   magnetometer_heading_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_x_low_byte   (req_x_low_byte),
      .req_x_high_byte  (req_x_high_byte),
      .req_y_low_byte   (req_y_low_byte),
      .req_y_high_byte  (req_y_high_byte),
      .req_z_low_byte   (req_z_low_byte),
      .req_z_high_byte  (req_z_high_byte),
      .rsp_strobe       (rsp_strobe),
      .rsp_x_value      (rsp_x_value),
      .rsp_y_value      (rsp_y_value),
      .rsp_z_value      (rsp_z_value),
      .rsp_heading_deg64(rsp_heading_deg64)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sample both channels at the edge, before any driver update lands.
   // A word is taken when start is high and busy is low.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            board.note_reading(req_x_low_byte, req_x_high_byte, req_y_low_byte,
                               req_y_high_byte, req_z_low_byte, req_z_high_byte);
            words_taken++;
         end
         if (rsp_strobe) begin
            board.check_result(rsp_x_value, rsp_y_value, rsp_z_value, rsp_heading_deg64);
            results_seen++;
         end
      end
   end

   // Present one burst and hold it until the monitor has seen it taken.
   // Returns in the time step of the accepting edge.
   task automatic send_axes(input shortint x_axis, input shortint y_axis, input shortint z_axis);
      int target;
      target = words_taken + 1;
      start           <= 1'b1;
      req_x_low_byte  <= x_axis[7:0];
      req_x_high_byte <= x_axis[15:8];
      req_y_low_byte  <= y_axis[7:0];
      req_y_high_byte <= y_axis[15:8];
      req_z_low_byte  <= z_axis[7:0];
      req_z_high_byte <= z_axis[15:8];
      wait (words_taken >= target);
   endtask

   // Drop start for an idle gap; scramble the idle data bus meanwhile.
   task automatic idle_cycles(input int n);
      if (n > 0) begin
         start           <= 1'b0;
         req_x_low_byte  <= 8'($urandom);
         req_x_high_byte <= 8'($urandom);
         req_y_low_byte  <= 8'($urandom);
         req_y_high_byte <= 8'($urandom);
         req_z_low_byte  <= 8'($urandom);
         req_z_high_byte <= 8'($urandom);
         repeat (n) @(posedge clock);
      end
   endtask

   // Mostly back-to-back or short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 80);
   endfunction

   // Hold the sender until every outstanding word has come back.
   task automatic drain_pipe();
      start <= 1'b0;
      drain_pauses++;
      while (results_seen < words_taken) begin
         @(posedge clock);
      end
      @(posedge clock);
   endtask

   task automatic directed_axes(input shortint x_axis, input shortint y_axis,
                                input shortint z_axis);
      send_axes(x_axis, y_axis, z_axis);
      directed_words++;
      idle_cycles(pick_gap());
   endtask

   initial begin
      shortint xv;
      shortint yv;
      shortint zv;
      int      kind;
      int      gap;
      int      guard;
      int      fails;
      reset           = 1'b1;
      start           = 1'b0;
      req_x_low_byte  = 8'h00;
      req_x_high_byte = 8'h00;
      req_y_low_byte  = 8'h00;
      req_y_high_byte = 8'h00;
      req_z_low_byte  = 8'h00;
      req_z_high_byte = 8'h00;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // both axes zero gives heading 0
      directed_axes(16'sd0, 16'sd0, 16'sd0);
      // the four compass points at full scale
      directed_axes(16'sd0, 16'sd32767, 16'sd0);
      directed_axes(16'sd32767, 16'sd0, -16'sd1);
      directed_axes(16'sd0, -16'sd32768, 16'sd32767);
      directed_axes(-16'sd32768, 16'sd0, -16'sd32768);
      // diagonals and near-diagonals, tiny and full scale
      directed_axes(16'sd1, 16'sd1, 16'sh55AA);
      directed_axes(-16'sd1, 16'sd1, 16'shAA55);
      directed_axes(16'sd1, -16'sd1, 16'sd0);
      directed_axes(-16'sd1, -16'sd1, 16'sd1);
      directed_axes(16'sd32767, 16'sd32767, 16'sd0);
      directed_axes(-16'sd32768, -16'sd32768, 16'sd0);
      directed_axes(16'sd32767, -16'sd32768, 16'sd0);
      directed_axes(-16'sd32768, 16'sd32767, 16'sd0);
      // just below a full turn: rounds up to 360 and wraps to 0
      directed_axes(-16'sd1, 16'sd32767, 16'sd0);
      directed_axes(-16'sd2, 16'sd32767, 16'sd0);
      directed_axes(-16'sd1, 16'sd20000, 16'sd0);
      // just past north, and the smallest nonzero vectors
      directed_axes(16'sd1, 16'sd32767, 16'sd0);
      directed_axes(16'sd0, 16'sd1, 16'sd0);
      directed_axes(16'sd1, 16'sd0, 16'sd0);
      directed_axes(16'sd0, -16'sd1, 16'sd0);
      directed_axes(-16'sd1, 16'sd0, 16'sd0);
      directed_axes(-16'sd32768, -16'sd1, 16'sd0);
      drain_pipe();

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         kind = $urandom_range(99);
         zv   = shortint'($urandom);
         if (kind < 40) begin
            xv = shortint'($urandom);
            yv = shortint'($urandom);
         end else if (kind < 60) begin
            // small magnitudes push the normalizing shift around
            xv = shortint'($urandom) >>> $urandom_range(0, 15);
            yv = shortint'($urandom) >>> $urandom_range(0, 15);
         end else if (kind < 75) begin
            // one axis zero: compass points
            xv = shortint'($urandom) >>> $urandom_range(0, 15);
            yv = shortint'($urandom) >>> $urandom_range(0, 15);
            if ($urandom_range(1)) begin
               xv = 16'sd0;
            end else begin
               yv = 16'sd0;
            end
         end else if (kind < 85) begin
            // diagonals with random signs
            xv = shortint'($urandom) >>> $urandom_range(0, 15);
            if (xv == -16'sd32768) begin
               yv = xv;
            end else begin
               yv = $urandom_range(1) ? xv : -xv;
            end
         end else if (kind < 95) begin
            // near the wrap at north, both sides of it
            yv = shortint'($urandom_range(1, 32767));
            xv = shortint'($urandom_range(0, 8)) * ($urandom_range(1) ? 16'sd1 : -16'sd1);
         end else begin
            xv = $urandom_range(1) ? -16'sd32768 : 16'sd0;
            yv = $urandom_range(1) ? 16'sd32767 : 16'sd0;
         end
         send_axes(xv, yv, zv);
         // keep a back-to-back stretch in every few hundred words
         gap = ((i % 300) < 40) ? 0 : pick_gap();
         if (i == RANDOM_WORDS / 2) begin
            drain_pipe();
         end else begin
            idle_cycles(gap);
         end
      end

      start <= 1'b0;
      for (guard = 0; guard < 1000 && results_seen < words_taken; guard++) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.pending() != 0) begin
         $error("%0d expected results never arrived", board.pending());
      end
      fails = board.mismatches + board.pending();
      $display("Sent %0d bursts (%0d directed: compass points, diagonals, wrap at north),",
               words_taken, directed_words);
      $display("checked %0d results against the predictor, %0d full drain pauses.",
               board.checked, drain_pauses);
      if (fails == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
